[sv/ofc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ofc_pkg: shared types, codes and helpers for the box culling block
// Holds the word and dot-product types, operation and register codes, and the
// saturation helpers used by the datapath and the radius compare.
// ----------------------------------------------------------------------------
package ofc_pkg;

    // Configuration port geometry and register codes.
    localparam int         ADDR_W          = 3;
    localparam logic [0:0] REG_PLANE_COUNT = 1'b0;
    localparam logic [2:0] PLANE_COUNT_RST = 3'd6;

    // Operation codes carried by an input beat.
    typedef enum logic [1:0] {
        OP_LOAD_PLANE = 2'd0,
        OP_LOAD_ROW   = 2'd1,
        OP_TEST       = 2'd2
    } t_op;

    typedef logic signed [31:0] t_word;

    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    // The four finished dot products of one plane.
    typedef struct packed {
        t_word dot_ax;
        t_word dot_ay;
        t_word dot_az;
        t_word dot_g;
    } t_dots;

    // Tag that travels with a store read down the pipeline.
    typedef struct packed {
        logic       plane;
        logic [1:0] row;
        logic [1:0] elem;
    } t_tag;

    // Saturate a wide signed sum to a 32-bit word.
    function automatic t_word sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return WORD_MAX;
        end else if (v < -64'sd2147483648) begin
            return WORD_MIN;
        end
        return t_word'(v);
    endfunction

    // Absolute value, with the most negative word clamped to the largest.
    function automatic logic [30:0] abs_sat(input t_word v);
        t_word neg;
        neg = -v;
        if (v == WORD_MIN) begin
            return '1;
        end else if (v < 0) begin
            return neg[30:0];
        end
        return v[30:0];
    endfunction

endpackage
`default_nettype wire

[sv/ofc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ofc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data shows in the cycle
// after the address.
// ----------------------------------------------------------------------------
module ofc_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/ofc_radius.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ofc_radius: effective radius and reject test for one plane
// Sums the saturated magnitudes of the three axis projections, halves the
// sum and flags the box outside when the negated radius reaches the centre
// distance.
// ----------------------------------------------------------------------------
module ofc_radius (
    input  wire ofc_pkg::t_dots i_dots,
    output logic                o_outside
);

    import ofc_pkg::*;

    logic        [30:0] mag_x;
    logic        [30:0] mag_y;
    logic        [30:0] mag_z;
    logic        [32:0] mag_sum;
    logic        [30:0] mag_sat;
    logic        [29:0] radius;
    logic signed [32:0] neg_radius;
    logic signed [32:0] center_dist;

    // Magnitudes of the axis projections.
    assign mag_x = abs_sat(i_dots.dot_ax);
    assign mag_y = abs_sat(i_dots.dot_ay);
    assign mag_z = abs_sat(i_dots.dot_az);

    // Saturated sum, then halved.
    assign mag_sum = {2'b00, mag_x} + {2'b00, mag_y} + {2'b00, mag_z};
    assign mag_sat = (mag_sum > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : mag_sum[30:0];
    assign radius  = mag_sat[30:1];

    // The box lies outside when -radius >= plane distance of the centre.
    assign neg_radius  = -$signed({3'b000, radius});
    assign center_dist = 33'(i_dots.dot_g);
    assign o_outside   = (neg_radius >= center_dist);

endmodule
`default_nettype wire

[sv/obb_frustum_cull_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obb_frustum_cull_top: oriented box against view frustum culling
// Loads frustum planes and transform rows into two stores, then tests boxes
// with the effective radius method through a read-multiply-accumulate pipe.
// ----------------------------------------------------------------------------
// Sequence: a test reads the transform rows, waits for the pipe to empty, then
// reads each of the n active planes (none when n is zero). A new beat is taken
// only in S_IDLE, once a load is written or a test's result is registered.
// The pace is set by the single read or write port of each store, which moves
// one word per cycle: 16 transform words, then 4 words per plane. Reset is
// synchronous and active low; it empties the pipe and sets plane_count to 6.
// ----------------------------------------------------------------------------
module obb_frustum_cull_top #(
    parameter int MAX_PLANES    = 6,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Input channel.
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_op,
    input  wire logic [2:0]                 i_slot,
    input  wire ofc_pkg::t_word             i_word_a,
    input  wire ofc_pkg::t_word             i_word_b,
    input  wire ofc_pkg::t_word             i_word_c,
    input  wire ofc_pkg::t_word             i_word_d,
    input  wire ofc_pkg::t_word             i_box_height,
    input  wire ofc_pkg::t_word             i_box_depth,
    // Result channel.
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_inside_res,
    // Configuration port.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ofc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);

    import ofc_pkg::*;

    localparam int PA_W  = $clog2(4 * MAX_PLANES);
    localparam int KW    = $clog2(MAX_PLANES + 1);
    localparam int SH_W  = 64 - FRACTION_BITS;
    localparam int ACC_W = SH_W + 2;

    localparam t_word           ONE_Q = t_word'(1 << FRACTION_BITS);
    localparam logic [KW-1:0]   N_MAX = KW'(MAX_PLANES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_XFORM,
        S_XWAIT,
        S_PLANE,
        S_DRAIN,
        S_DONE
    } t_state;

    // Control and captured beat.
    t_state        r_state;
    logic [1:0]    r_op;
    logic [2:0]    r_slot;
    t_word         r_wa;
    t_word         r_wb;
    t_word         r_wc;
    t_word         r_wd;
    t_word         r_hgt;
    t_word         r_dep;
    logic [KW-1:0] r_n;
    logic [1:0]    r_cnt;
    logic [1:0]    r_row;
    logic [KW-1:0] r_k;
    logic          r_inside;
    logic          r_out_valid;
    logic          r_out_inside;
    logic [2:0]    r_plane_count;

    // Pipeline registers.
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    t_tag                    r_t1;
    t_tag                    r_t2;
    logic signed [63:0]      r_prod [4];
    logic signed [ACC_W-1:0] r_acc  [4];
    t_word                   r_ax   [4];
    t_word                   r_ay   [4];
    t_word                   r_az   [4];
    t_word                   r_g    [4];
    t_dots                   r_dots;

    logic                    pipe_busy;
    logic                    cfg_hit;
    logic [KW-1:0]           n_n;
    logic                    plane_we;
    logic                    row_we;
    logic [PA_W-1:0]         plane_waddr;
    logic [PA_W-1:0]         plane_raddr;
    logic [3:0]              row_waddr;
    logic [3:0]              row_raddr;
    t_word                   wr_word;
    logic [31:0]             plane_rdata;
    logic [31:0]             row_rdata;
    t_word                   mul_a;
    t_word                   mul_b  [4];
    logic signed [63:0]      n_prod [4];
    logic signed [SH_W-1:0]  shifted [4];
    logic signed [ACC_W-1:0] n_sum  [4];
    logic                    outside;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_inside;
    assign pipe_busy    = r_v1 | r_v2 | r_v3;

    // Configuration register.
    assign cfg_hit = (paddr[ADDR_W-1:2] == REG_PLANE_COUNT);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {29'd0, r_plane_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_count <= PLANE_COUNT_RST;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_plane_count <= pwdata[2:0];
        end
    end

    // Active plane count, clamped to the store size.
    assign n_n = (32'(r_plane_count) > MAX_PLANES) ? N_MAX : KW'(r_plane_count);

    // Store write and read addressing.
    assign plane_we    = (r_state == S_LOAD) && (r_op == OP_LOAD_PLANE) &&
                         (32'(r_slot) < MAX_PLANES);
    assign row_we      = (r_state == S_LOAD) && (r_op == OP_LOAD_ROW) && !r_slot[2];
    assign plane_waddr = PA_W'({r_slot, r_cnt});
    assign row_waddr   = {r_slot[1:0], r_cnt};
    assign plane_raddr = PA_W'({r_k, r_cnt});
    assign row_raddr   = {r_row, r_cnt};

    always_comb begin
        unique case (r_cnt)
            2'd0: wr_word = r_wa;
            2'd1: wr_word = r_wb;
            2'd2: wr_word = r_wc;
            2'd3: wr_word = r_wd;
        endcase
    end

    ofc_ram #(
        .WIDTH (32),
        .DEPTH (4 * MAX_PLANES)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (plane_we),
        .i_waddr (plane_waddr),
        .i_wdata (wr_word),
        .i_raddr (plane_raddr),
        .o_rdata (plane_rdata)
    );

    ofc_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (wr_word),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // Multiplier operands: plane words meet the transformed vectors, matrix
    // words meet the homogeneous centre and the box extents.
    always_comb begin
        mul_a = r_t1.plane ? t_word'(plane_rdata) : t_word'(row_rdata);
        if (r_t1.plane) begin
            mul_b[0] = r_ax[r_t1.elem];
            mul_b[1] = r_ay[r_t1.elem];
            mul_b[2] = r_az[r_t1.elem];
            mul_b[3] = r_g[r_t1.elem];
        end else begin
            unique case (r_t1.elem)
                2'd0: begin
                    mul_b[0] = r_wa;
                    mul_b[1] = r_wd;
                end
                2'd1: begin
                    mul_b[0] = r_wb;
                    mul_b[1] = r_hgt;
                end
                2'd2: begin
                    mul_b[0] = r_wc;
                    mul_b[1] = r_dep;
                end
                2'd3: begin
                    mul_b[0] = ONE_Q;
                    mul_b[1] = '0;
                end
            endcase
            mul_b[2] = '0;
            mul_b[3] = '0;
        end
    end

    // Full-width products, floor shift and running sums.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_prod[i]  = 64'(mul_a) * 64'(mul_b[i]);
            shifted[i] = SH_W'(r_prod[i] >>> FRACTION_BITS);
            n_sum[i]   = ((r_t2.elem == 2'd0) ? ACC_W'(0) : r_acc[i]) + ACC_W'(shifted[i]);
        end
    end

    // Read, multiply and accumulate pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_XFORM) || (r_state == S_PLANE);
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_t2.plane && (r_t2.elem == 2'd3);
        end

        r_t1.plane <= (r_state == S_PLANE);
        r_t1.row   <= r_row;
        r_t1.elem  <= r_cnt;
        r_t2       <= r_t1;
        for (int i = 0; i < 4; i++) begin
            r_prod[i] <= n_prod[i];
        end

        if (r_v2) begin
            for (int i = 0; i < 4; i++) begin
                r_acc[i] <= n_sum[i];
            end
            if (r_t2.plane) begin
                // Plane dot products finish on the last coefficient.
                if (r_t2.elem == 2'd3) begin
                    r_dots.dot_ax <= sat32(64'(n_sum[0]));
                    r_dots.dot_ay <= sat32(64'(n_sum[1]));
                    r_dots.dot_az <= sat32(64'(n_sum[2]));
                    r_dots.dot_g  <= sat32(64'(n_sum[3]));
                end
            end else begin
                // Transformed centre row, and the one-term axis entries.
                unique case (r_t2.elem)
                    2'd0: r_ax[r_t2.row] <= sat32(64'(shifted[1]));
                    2'd1: r_ay[r_t2.row] <= sat32(64'(shifted[1]));
                    2'd2: r_az[r_t2.row] <= sat32(64'(shifted[1]));
                    2'd3: r_g[r_t2.row]  <= sat32(64'(n_sum[0]));
                endcase
            end
        end
    end

    ofc_radius u_radius (
        .i_dots    (r_dots),
        .o_outside (outside)
    );

    // Sequencer and result register. A finishing test refills the result
    // register itself, so the plain release only applies outside S_DONE.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_op;
                        r_slot   <= i_slot;
                        r_wa     <= i_word_a;
                        r_wb     <= i_word_b;
                        r_wc     <= i_word_c;
                        r_wd     <= i_word_d;
                        r_hgt    <= i_box_height;
                        r_dep    <= i_box_depth;
                        r_n      <= n_n;
                        r_cnt    <= 2'd0;
                        r_row    <= 2'd0;
                        r_k      <= '0;
                        r_inside <= 1'b1;
                        priority if (i_op == OP_LOAD_PLANE || i_op == OP_LOAD_ROW) begin
                            r_state <= S_LOAD;
                        end else if (i_op == OP_TEST) begin
                            r_state <= S_XFORM;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_LOAD: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_IDLE;
                    end
                end
                S_XFORM: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_row <= r_row + 2'd1;
                        if (r_row == 2'd3) begin
                            r_state <= S_XWAIT;
                        end
                    end
                end
                S_XWAIT: begin
                    // The plane pass needs every transformed entry in place.
                    if (!pipe_busy) begin
                        r_state <= (r_n == '0) ? S_DONE : S_PLANE;
                    end
                end
                S_PLANE: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_k <= r_k + KW'(1);
                        if (r_k == r_n - KW'(1)) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!pipe_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_inside <= r_inside;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Any rejecting plane culls the box.
            if (r_v3 && outside) begin
                r_inside <= 1'b0;
            end
        end
    end

    // Checks on the sequencing.
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !pipe_busy)
        else $error("pipeline active while the block is idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the finishing step");

    a_no_phase_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_t2.plane) |-> !(r_v1 && !r_t1.plane))
        else $error("transform read behind a plane read in the pipe");

    a_plane_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLANE) |-> (r_k < r_n))
        else $error("plane read beyond the active count");

endmodule
`default_nettype wire
